// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared codes, widths and the CRC-16/CCITT-FALSE byte update for the
// serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int LEN_W  = 16;
   localparam int HDR_LEN = 8;

   // receive phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SYNC2   = 3'd1;
   localparam logic [2:0] PH_HEADER  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRC_LO  = 3'd4;
   localparam logic [2:0] PH_CRC_HI  = 3'd5;

   // result kinds
   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_FRAME_END = 3'd1;
   localparam logic [2:0] KIND_LINE_CHAR = 3'd3;
   localparam logic [2:0] KIND_LINE_END  = 3'd4;
   localparam logic [2:0] KIND_LINE_DROP = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_VERSION     = 2'd2;

   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_TILDE = 8'h7E;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic        crc_ok;
      logic [8:0]  payload_length;
      logic [7:0]  frame_flags;
      logic [15:0] sequence_number;
      logic [15:0] frame_id;
      logic [7:0]  data_byte;
   } rsp_data_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== sv/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Sync-hunting frame receiver with header checks, payload streaming,
// CRC-16/CCITT-FALSE check and an ASCII line channel for bytes between frames.
//
//   channel | direction | transfer carries
//   req_    | in        | tdata[7:0] rx_byte
//   rsp_    | out       | tuser[2:0] kind, tdata packed result fields
//   csr_    | in        | write enable, register index, 8-bit data
//
// One byte is taken per cycle while req_tready is high; its state step and CRC
// update finish in the accepting cycle and any result lands in the output
// register the next cycle. req_tready drops only while a result is held and
// rsp_tready is low. Reset is synchronous.
// ----------------------------------------------------------------------------
module serial_frame_receiver #(
   parameter int MAX_PAYLOAD   = 256,
   parameter int LINE_CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // data_byte, frame_id, sequence_number,
                                    // frame_flags, payload_length, crc_ok, zero pad
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int IDX_BITS = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W    = (IDX_BITS > 4) ? IDX_BITS : 4;
   localparam int LC_W     = $clog2(LINE_CAPACITY);

   logic [7:0] sync_first_ff, sync_second_ff, version_ff;

   logic [2:0]                phase_ff, phase_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [7:0]                hdr_ff [sfr_pkg::HDR_LEN];
   logic                      hdr_we;
   logic [15:0]               crc_ff, crc_in;
   logic [7:0]                crc_lo_ff, crc_lo_in;
   logic [sfr_pkg::LEN_W-1:0] len_ff, len_in;
   logic [LC_W-1:0]           line_ff, line_in;

   logic                  rsp_valid_ff;
   logic [2:0]            rsp_kind_ff;
   sfr_pkg::rsp_data_type rsp_data_ff;

   logic                  req_accept;
   logic                  emit;
   logic                  line_go;
   logic [2:0]            kind;
   sfr_pkg::rsp_data_type data;
   logic [7:0]            b;
   logic [sfr_pkg::LEN_W-1:0] hdr_len;

   assign b          = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign hdr_len    = {b, hdr_ff[6]};

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      len_in    = len_ff;
      line_in   = line_ff;
      hdr_we    = 1'b0;
      emit      = 1'b0;
      line_go   = 1'b0;
      kind      = sfr_pkg::KIND_PAYLOAD;
      data      = '0;
      unique case (phase_ff)
         sfr_pkg::PH_IDLE: begin
            if (b == sync_first_ff) begin
               phase_in = sfr_pkg::PH_SYNC2;
            end else begin
               line_go = 1'b1;
            end
         end
         sfr_pkg::PH_SYNC2: begin
            if (b == sync_second_ff) begin
               idx_in   = '0;
               crc_in   = sfr_pkg::CRC_INIT;
               phase_in = sfr_pkg::PH_HEADER;
            end else begin
               phase_in = sfr_pkg::PH_IDLE;
               line_go  = 1'b1;
            end
         end
         sfr_pkg::PH_HEADER: begin
            hdr_we = 1'b1;
            crc_in = sfr_pkg::crc16_byte(crc_ff, b);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(sfr_pkg::HDR_LEN - 1)) begin
               len_in = hdr_len;
               idx_in = '0;
               if (hdr_ff[0] != version_ff ||
                   hdr_len > sfr_pkg::LEN_W'(MAX_PAYLOAD)) begin
                  phase_in = sfr_pkg::PH_IDLE;
               end else if (hdr_len == '0) begin
                  phase_in = sfr_pkg::PH_CRC_LO;
               end else begin
                  phase_in = sfr_pkg::PH_PAYLOAD;
               end
            end
         end
         sfr_pkg::PH_PAYLOAD: begin
            crc_in = sfr_pkg::crc16_byte(crc_ff, b);
            idx_in = idx_ff + 1'b1;
            if ((sfr_pkg::LEN_W + 1)'(idx_ff) + 1'b1 >= {1'b0, len_ff}) begin
               phase_in = sfr_pkg::PH_CRC_LO;
            end
            emit           = 1'b1;
            kind           = sfr_pkg::KIND_PAYLOAD;
            data.data_byte = b;
         end
         sfr_pkg::PH_CRC_LO: begin
            crc_lo_in = b;
            phase_in  = sfr_pkg::PH_CRC_HI;
         end
         sfr_pkg::PH_CRC_HI: begin
            emit                 = 1'b1;
            kind                 = sfr_pkg::KIND_FRAME_END;
            data.frame_id        = {hdr_ff[3], hdr_ff[2]};
            data.sequence_number = {hdr_ff[5], hdr_ff[4]};
            data.frame_flags     = hdr_ff[1];
            data.payload_length  = len_ff[8:0];
            data.crc_ok          = ({b, crc_lo_ff} == crc_ff);
            phase_in             = sfr_pkg::PH_IDLE;
         end
         default: begin
            phase_in = sfr_pkg::PH_IDLE;
         end
      endcase

      if (line_go) begin
         priority if (b == sfr_pkg::ASCII_CR) begin
            line_in = line_ff;
         end else if (b == sfr_pkg::ASCII_LF) begin
            emit    = (line_ff != '0);
            kind    = sfr_pkg::KIND_LINE_END;
            line_in = '0;
         end else if (line_ff >= LC_W'(LINE_CAPACITY - 1)) begin
            emit    = 1'b1;
            kind    = sfr_pkg::KIND_LINE_DROP;
            line_in = '0;
         end else if (b >= sfr_pkg::ASCII_SPACE && b <= sfr_pkg::ASCII_TILDE) begin
            emit           = 1'b1;
            kind           = sfr_pkg::KIND_LINE_CHAR;
            data.data_byte = b;
            line_in        = line_ff + 1'b1;
         end else begin
            line_in = line_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= 8'hAA;
         sync_second_ff <= 8'h55;
         version_ff     <= 8'h01;
      end else if (csr_we) begin
         unique case (csr_index)
            sfr_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            sfr_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            sfr_pkg::CSR_VERSION:     version_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sfr_pkg::PH_IDLE;
         idx_ff    <= '0;
         crc_ff    <= sfr_pkg::CRC_INIT;
         crc_lo_ff <= '0;
         len_ff    <= '0;
         line_ff   <= '0;
      end else if (req_accept) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
         len_ff    <= len_in;
         line_ff   <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && hdr_we) begin
         hdr_ff[idx_ff[2:0]] <= b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_kind_ff <= kind;
         rsp_data_ff <= data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   // a byte taken in the last CRC phase always yields a frame end
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == sfr_pkg::PH_CRC_HI
      |=> rsp_tvalid && rsp_tuser == sfr_pkg::KIND_FRAME_END)
      else $error("frame end missing after trailing CRC byte");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      line_ff <= LC_W'(LINE_CAPACITY - 1))
      else $error("line count past capacity");

   a_payload_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfr_pkg::PH_PAYLOAD
      |-> (sfr_pkg::LEN_W + 1)'(idx_ff) < {1'b0, len_ff})
      else $error("payload index beyond frame length");

   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfr_pkg::PH_PAYLOAD || phase_ff == sfr_pkg::PH_CRC_LO
      |-> len_ff <= sfr_pkg::LEN_W'(MAX_PAYLOAD))
      else $error("accepted frame length over limit");

   a_no_result_without_byte: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !req_accept |=> !rsp_tvalid)
      else $error("result appeared without an input transfer");

endmodule
